FILE: rtl/core/plcs_pkg.sv
// ============================================================================
// plcs_pkg
// Shared types, constants and CRC helpers of the packet length and CRC signer.
// ============================================================================
`default_nettype none

package plcs_pkg;

    localparam int          MAX_PACKET_BYTES = 4096;
    localparam int          POS_W            = 13;
    localparam int          CNT_W            = POS_W + 1;
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [15:0] CRC_INIT         = 16'h1021;
    localparam logic [7:0]  SIG_PAD_BYTE     = 8'h30;
    localparam int          SIG_PAD_COUNT    = 32;
    localparam int          SIG_BYTES        = 4;
    localparam int          SIG_CNT_W        = $clog2(SIG_BYTES + 1);
    localparam int          QUEUE_DEPTH      = 4;
    localparam int          QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int          QUEUE_CW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef enum logic [1:0]
    {
        KIND_PASS     = 2'd0,
        KIND_GOOD_END = 2'd1,
        KIND_BAD_END  = 2'd2
    } entry_kind_t;

    typedef struct packed
    {
        logic [7:0]  data;
        logic [15:0] crc;
        entry_kind_t kind;
    } plcs_entry_t;

    typedef logic [15:0][15:0] sig_matrix_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] sig_crc_full(input logic [15:0] crc);
        logic [15:0] c;
        c = crc_byte(CRC_INIT, crc[7:0]);
        c = crc_byte(c, crc[15:8]);
        for (int i = 0; i < SIG_PAD_COUNT; i++)
        begin
            c = crc_byte(c, SIG_PAD_BYTE);
        end
        return c;
    endfunction

    function automatic sig_matrix_t sig_columns();
        sig_matrix_t m;
        logic [15:0] z;
        z = sig_crc_full(16'h0000);
        for (int i = 0; i < 16; i++)
        begin
            m[i] = sig_crc_full(16'(1) << i) ^ z;
        end
        return m;
    endfunction

    localparam logic [15:0] SIG_OFFSET = sig_crc_full(16'h0000);
    localparam sig_matrix_t SIG_COLS   = sig_columns();

    // second CRC is affine in the first: XOR of constant columns
    function automatic logic [15:0] sig_crc(input logic [15:0] crc);
        logic [15:0] r;
        r = SIG_OFFSET;
        for (int i = 0; i < 16; i++)
        begin
            if (crc[i])
            begin
                r = r ^ SIG_COLS[i];
            end
        end
        return r;
    endfunction

    // hex text of the total, left-justified to four nibbles
    function automatic logic [15:0] length_word(input logic [CNT_W-1:0] total);
        logic [15:0] t;
        logic [15:0] w;
        t = 16'(total);
        priority if (t[15:12] != 4'h0)
        begin
            w = t;
        end
        else if (t[11:8] != 4'h0)
        begin
            w = t << 4;
        end
        else if (t[7:4] != 4'h0)
        begin
            w = t << 8;
        end
        else
        begin
            w = t << 12;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/packet_length_and_crc_signer.sv
// ============================================================================
// packet_length_and_crc_signer
// Stamps the length word into bytes 2 and 3 and appends a CRC-16 signature.
// ============================================================================
// Path: each byte passes through a queue slot and then the output register.
// Throughput: one byte per cycle while the master side accepts; a good packet
// adds four signature bytes at its end, and the 4-entry queue between the front
// and back parts keeps the slave side accepting until it fills.
// Reset: CRC state to 0x1021, byte position to 0, queue and output empty.
`default_nettype none

module packet_length_and_crc_signer
    import plcs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // data_byte[7:0], packet_bytes[20:8], zero
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // out_byte[7:0]
    output logic [1:0]        m_axis_tuser,   // is_signature[0], frame_error[1]
    output logic              m_axis_tlast
);

    logic        push;
    plcs_entry_t push_entry;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    plcs_entry_t head;
    logic        sig_flag;
    logic        err_flag;

    plcs_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .data_byte    (s_axis_tdata[7:0]),
        .packet_bytes (s_axis_tdata[20:8]),
        .last         (s_axis_tlast),
        .push         (push),
        .entry        (push_entry),
        .queue_full   (queue_full)
    );

    plcs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    plcs_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata),
        .is_signature (sig_flag),
        .frame_end    (m_axis_tlast),
        .frame_error  (err_flag)
    );

    assign m_axis_tuser = {err_flag, sig_flag};

endmodule

`default_nettype wire

FILE: rtl/core/plcs_front.sv
// ============================================================================
// plcs_front
// Accepts input beats, stamps the length word, updates the CRC and classifies
// the end of each packet.
// ============================================================================
`default_nettype none

module plcs_front
    import plcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic [POS_W-1:0]   packet_bytes,
    input  wire logic               last,
    output logic                    push,
    output plcs_entry_t             entry,
    input  wire logic               queue_full
);

    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      len_word;
    logic [7:0]       out_byte;
    logic [15:0]      crc_new;
    logic [CNT_W-1:0] count;
    logic             bad;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    assign len_word = length_word(CNT_W'(packet_bytes) + CNT_W'(4));

    always_comb
    begin
        out_byte = data_byte;
        if (pos_reg == POS_W'(2))
        begin
            out_byte = len_word[15:8];
        end
        else if (pos_reg == POS_W'(3))
        begin
            out_byte = len_word[7:0];
        end
    end

    assign crc_new = crc_byte(crc_reg, out_byte);
    assign count   = CNT_W'(pos_reg) + CNT_W'(1);
    assign bad     = (count < CNT_W'(4)) || (count != CNT_W'(packet_bytes))
                     || (32'(packet_bytes) > 32'(MAX_PACKET_BYTES));

    always_comb
    begin
        entry.data = out_byte;
        entry.crc  = crc_new;
        if (!last)
        begin
            entry.kind = KIND_PASS;
        end
        else if (bad)
        begin
            entry.kind = KIND_BAD_END;
        end
        else
        begin
            entry.kind = KIND_GOOD_END;
        end
    end

    always_comb
    begin
        crc_next = crc_reg;
        pos_next = pos_reg;
        if (push)
        begin
            if (last)
            begin
                crc_next = CRC_INIT;
                pos_next = '0;
            end
            else
            begin
                crc_next = crc_new;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            pos_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/plcs_queue.sv
// ============================================================================
// plcs_queue
// Short register queue between the front and back parts.
// ============================================================================
`default_nettype none

module plcs_queue
    import plcs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire plcs_entry_t  push_entry,
    output logic              full,
    input  wire logic         pop,
    output logic              head_valid,
    output plcs_entry_t       head
);

    plcs_entry_t                   slot_reg [QUEUE_DEPTH];
    logic        [QUEUE_AW-1:0]    wr_ptr_reg;
    logic        [QUEUE_AW-1:0]    wr_ptr_next;
    logic        [QUEUE_AW-1:0]    rd_ptr_reg;
    logic        [QUEUE_AW-1:0]    rd_ptr_next;
    logic        [QUEUE_CW-1:0]    count_reg;
    logic        [QUEUE_CW-1:0]    count_next;
    logic                          do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/core/plcs_back.sv
// ============================================================================
// plcs_back
// Drains the queue into the output register and appends the four signature
// bytes after a good packet.
// ============================================================================
`default_nettype none

module plcs_back
    import plcs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire plcs_entry_t   head,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               is_signature,
    output logic               frame_end,
    output logic               frame_error
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [7:0]           byte_reg;
    logic [7:0]           byte_next;
    logic                 sig_reg;
    logic                 sig_next;
    logic                 end_reg;
    logic                 end_next;
    logic                 err_reg;
    logic                 err_next;
    logic [SIG_CNT_W-1:0] pend_reg;
    logic [SIG_CNT_W-1:0] pend_next;
    logic [31:0]          word_reg;
    logic [31:0]          word_next;
    logic                 slot_free;

    assign slot_free = !valid_reg || out_ready;
    assign pop       = slot_free && (pend_reg == '0) && head_valid;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        sig_next   = sig_reg;
        end_next   = end_reg;
        err_next   = err_reg;
        pend_next  = pend_reg;
        word_next  = word_reg;
        if (slot_free && (pend_reg != '0))
        begin
            // emit next signature byte
            valid_next = 1'b1;
            byte_next  = word_reg[7:0];
            sig_next   = 1'b1;
            end_next   = (pend_reg == SIG_CNT_W'(1));
            err_next   = 1'b0;
            pend_next  = pend_reg - SIG_CNT_W'(1);
            word_next  = word_reg >> 8;
        end
        else if (pop)
        begin
            valid_next = 1'b1;
            byte_next  = head.data;
            sig_next   = 1'b0;
            end_next   = (head.kind == KIND_BAD_END);
            err_next   = (head.kind == KIND_BAD_END);
            if (head.kind == KIND_GOOD_END)
            begin
                pend_next = SIG_CNT_W'(SIG_BYTES);
                word_next = {sig_crc(head.crc), head.crc};
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        sig_reg  <= sig_next;
        end_reg  <= end_next;
        err_reg  <= err_next;
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign is_signature = sig_reg;
    assign frame_end    = end_reg;
    assign frame_error  = err_reg;

    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= SIG_CNT_W'(SIG_BYTES))
        else $error("signature count out of range");

    a_pend_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0) |-> (valid_reg && !end_reg))
        else $error("frame end shown before signature done");

    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> (end_reg && !sig_reg))
        else $error("error flag off a frame end");

endmodule

`default_nettype wire

FILE: verif/packet_length_and_crc_signer_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// packet_length_and_crc_signer_tb
// Streams raw packets through the signer and checks every output beat against
// a cycle-free prediction of the length stamp, the CRC-16 signature and the
// error flagging. Covers short, mismatched and oversize packets.
// Both stream sides idle and stall at random.
// ============================================================================

module packet_length_and_crc_signer_tb;

    import plcs_pkg::*;

    typedef struct
    {
        logic [7:0]  data;
        logic [12:0] declared;
        logic        last;
    } raw_byte_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       is_signature;
        logic       frame_end;
        logic       frame_error;
    } signed_beat_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    raw_byte_t    raw_bytes[$];
    signed_beat_t signed_stream[$];
    raw_byte_t    next_byte;

    logic [15:0]      crc_state  = CRC_INIT;
    logic [POS_W-1:0] byte_index = '0;

    int burst_left;
    int gap_left;
    logic [15:0] ready_pattern;
    int pattern_age;

    int error_count     = 0;
    int beats_in        = 0;
    int beats_out       = 0;
    int packets_signed  = 0;
    int packets_refused = 0;

    packet_length_and_crc_signer u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] crc_advance(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    // left-justify the hex digits of the total into four nibbles
    function automatic logic [15:0] hex_length(input logic [13:0] total);
        logic [15:0] w;
        int k;
        w = 16'(total);
        for (k = 0; k < 3; k++)
        begin
            if (w[15:12] == 4'h0)
            begin
                w = w << 4;
            end
        end
        return w;
    endfunction

    function automatic void expect_beat(input logic [7:0] b, input logic sig,
                                        input logic fin, input logic err);
        signed_beat_t e;
        e.out_byte     = b;
        e.is_signature = sig;
        e.frame_end    = fin;
        e.frame_error  = err;
        signed_stream.push_back(e);
    endfunction

    task automatic stamp_and_sign(input logic [7:0] raw, input logic [12:0] declared,
                                  input logic last);
        logic [7:0]  b;
        logic [15:0] word;
        logic [15:0] crc;
        logic [15:0] sig;
        logic [13:0] count;
        int k;
        b = raw;
        if (byte_index == 2 || byte_index == 3)
        begin
            word = hex_length(14'(declared) + 14'd4);
            b = (byte_index == 2) ? word[15:8] : word[7:0];
        end
        crc = crc_advance(crc_state, b);
        if (!last)
        begin
            crc_state = crc;
            if (byte_index != POS_MAX)
            begin
                byte_index = byte_index + 1'b1;
            end
            expect_beat(b, 1'b0, 1'b0, 1'b0);
        end
        else
        begin
            count      = 14'(byte_index) + 14'd1;
            crc_state  = CRC_INIT;
            byte_index = '0;
            if (count < 14'd4 || count != 14'(declared) || declared > MAX_PACKET_BYTES)
            begin
                expect_beat(b, 1'b0, 1'b1, 1'b1);
                packets_refused++;
            end
            else
            begin
                sig = crc_advance(CRC_INIT, crc[7:0]);
                sig = crc_advance(sig, crc[15:8]);
                for (k = 0; k < SIG_PAD_COUNT; k++)
                begin
                    sig = crc_advance(sig, SIG_PAD_BYTE);
                end
                expect_beat(b, 1'b0, 1'b0, 1'b0);
                expect_beat(crc[7:0], 1'b1, 1'b0, 1'b0);
                expect_beat(crc[15:8], 1'b1, 1'b0, 1'b0);
                expect_beat(sig[7:0], 1'b1, 1'b0, 1'b0);
                expect_beat(sig[15:8], 1'b1, 1'b1, 1'b0);
                packets_signed++;
            end
        end
    endtask

    // negative declared: new random count on every byte; negative fill: random data
    task automatic queue_packet(input int n, input int declared, input int fill);
        raw_byte_t r;
        int k;
        for (k = 0; k < n; k++)
        begin
            r.data     = (fill < 0) ? 8'($urandom) : 8'(fill);
            r.declared = (declared < 0) ? 13'($urandom) : 13'(declared);
            r.last     = (k == n - 1);
            raw_bytes.push_back(r);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                stamp_and_sign(s_axis_tdata[7:0], s_axis_tdata[20:8], s_axis_tlast);
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left == 0 && raw_bytes.size() != 0)
                begin
                    next_byte = raw_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, next_byte.declared, next_byte.data};
                    s_axis_tlast  <= next_byte.last;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left != 0)
                    begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_pattern = 16'hFFFF;
            pattern_age   = 0;
        end
        else
        begin
            pattern_age++;
            if (pattern_age == 48)
            begin
                pattern_age = 0;
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom) | 16'h0001;
                    2: ready_pattern = 16'($urandom) | 16'($urandom) | 16'h0001;
                    default: ready_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
                endcase
            end
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
            m_axis_tready <= ready_pattern[0];
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_out++;
            if (signed_stream.size() == 0)
            begin
                $error("unexpected beat: out_byte %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                if (m_axis_tdata != signed_stream[0].out_byte)
                begin
                    $error("out_byte: expected %h, got %h",
                           signed_stream[0].out_byte, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[0] != signed_stream[0].is_signature)
                begin
                    $error("is_signature: expected %b, got %b",
                           signed_stream[0].is_signature, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tlast != signed_stream[0].frame_end)
                begin
                    $error("frame_end: expected %b, got %b",
                           signed_stream[0].frame_end, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser[1] != signed_stream[0].frame_error)
                begin
                    $error("frame_error: expected %b, got %b",
                           signed_stream[0].frame_error, m_axis_tuser[1]);
                    error_count++;
                end
                void'(signed_stream.pop_front());
            end
        end
    end

    initial
    begin
        int n;
        int queued;

        // directed: minimum good packets at data extremes, short, mismatch, oversize
        queue_packet(4, 4, 8'h00);
        queue_packet(4, 4, 8'hFF);
        queue_packet(1, 1, 8'hFF);
        queue_packet(2, 2, -1);
        queue_packet(3, 3, -1);
        queue_packet(5, 6, -1);
        queue_packet(4, 8191, -1);

        // random: mostly well-formed packets, some broken ones and noise
        queued = 0;
        while (queued < 280)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    n = $urandom_range(1, 3);
                    queue_packet(n, ($urandom_range(0, 1) == 0) ? n : $urandom_range(0, 8191), -1);
                end
                8:
                begin
                    n = $urandom_range(4, 16);
                    queue_packet(n, $urandom_range(0, 8191), -1);
                end
                9:
                begin
                    n = $urandom_range(1, 16);
                    queue_packet(n, -1, -1);
                end
                default:
                begin
                    n = $urandom_range(4, 16);
                    queue_packet(n, n, -1);
                end
            endcase
            queued += n;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (raw_bytes.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (signed_stream.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("covered %0d input beats and %0d output beats", beats_in, beats_out);
        $display("%0d packets signed, %0d refused (short, mismatched, oversize)",
                 packets_signed, packets_refused);
        if (error_count == 0)
        begin
            $display("packet_length_and_crc_signer_tb: done, clean");
        end
        else
        begin
            $display("packet_length_and_crc_signer_tb: done, errors");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout: %0d beats still expected", signed_stream.size());
        $display("packet_length_and_crc_signer_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/plcs_pkg.sv
rtl/core/plcs_front.sv
rtl/core/plcs_queue.sv
rtl/core/plcs_back.sv
rtl/core/packet_length_and_crc_signer.sv
verif/packet_length_and_crc_signer_tb.sv
